// ----- rtl/core/mme_pkg.sv -----
// Shared types, widths and helpers for the matrix multiply engine.
package mme_pkg;

	// Default largest matrix dimension
	localparam int MAX_DIM_DEF = 8;

	// Fixed field widths
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 35;
	localparam int IDX_W  = 6;
	localparam int POS_W  = 3;
	localparam int DIM_W  = 4;
	localparam int CIDX_W = 2;

	// Request codes
	localparam logic [1:0] REQ_WRITE_A = 2'd0;
	localparam logic [1:0] REQ_WRITE_B = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CIDX_W-1:0] REG_COLS_B    = 2'd2;

	// Tag that rides with each multiply-accumulate step
	typedef struct packed {
		logic             first;      // first term of a dot product
		logic             last_term;  // last term of a dot product
		logic             last_elem;  // last element of the product matrix
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} mac_tag_t;

	// Status from the datapath back to the sequencer
	typedef struct packed {
		logic adv;   // pipeline may advance this cycle
		logic done;  // final element moves into the output register
	} mac_stat_t;

	// Dimension register clamped to 1..maxd, returned minus one
	function automatic logic [DIM_W-1:0] clamp_m1(input logic [DIM_W-1:0] v,
	                                              input logic [DIM_W-1:0] maxd);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > maxd) begin
			r = maxd - DIM_W'(1);
		end else begin
			r = v - DIM_W'(1);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/mme_mac.sv -----
// Multiply-accumulate datapath with the result output register.
module mme_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_s1,
	input  mme_pkg::mac_tag_t           tag_s1,
	input  logic signed [mme_pkg::VAL_W-1:0] a_s1,
	input  logic signed [mme_pkg::VAL_W-1:0] b_s1,
	output mme_pkg::mac_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mme_pkg::POS_W-1:0]   out_row,
	output logic [mme_pkg::POS_W-1:0]   out_col,
	output logic signed [mme_pkg::ACC_W-1:0] product_value,
	output logic                        is_last
);
	import mme_pkg::*;

	logic                     v_s2;
	mac_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     out_valid_q;
	logic                     adv;
	logic                     load_out;

	// Whole pipeline holds while a word waits in the output register
	assign adv      = !out_valid_q || out_ready;
	assign load_out = v_s2 && tag_s2.last_term && adv;

	assign stat.adv  = adv;
	assign stat.done = load_out && tag_s2.last_elem;

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= tag_s1;
			prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		end
	end

	// Accumulate; first term restarts the sum
	assign acc_next = (tag_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (v_s2 && adv) begin
			acc_q <= acc_next;
		end
		if (load_out) begin
			product_value <= acc_next;
			out_row       <= tag_s2.row;
			out_col       <= tag_s2.col;
			is_last       <= tag_s2.last_elem;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Held output word never gets overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load_out)
		else $error("output word overwritten while stalled");

	// A finished element is only loaded from a valid step
	a_load_tag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> v_s2)
		else $error("output loaded without a valid step");

	// While stalled the multiply stage keeps its contents
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s2) && $stable(prod_s2))
		else $error("multiply stage moved during stall");

endmodule

// ----- rtl/core/matrix_multiply_engine_core.sv -----
// Top level: element stores, dimension registers and the product sequencer.
//
//  channel   signals                                     direction
//  input     in_valid/in_ready, req_type, elem_index,    in
//            elem_value
//  output    out_valid/out_ready, out_row, out_col,      out
//            product_value, is_last
//  config    cfg_wr_en, cfg_index, cfg_data              in
//
// A compute word walks rows*cols*inner multiply-accumulate steps, one a
// cycle while the output register is not stalled, through the single read
// port of each store and the one shared multiplier. The step that reads
// the last term of a result feeds the read stage registers, then the
// multiply stage, then the output register. in_ready drops from a compute
// accept until its last result is in the output register. A stalled output
// register freezes the whole walk. Reset restores all dimensions to 8;
// store contents are left as they are.
module matrix_multiply_engine_core #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [mme_pkg::IDX_W-1:0]        elem_index,
	input  logic signed [mme_pkg::VAL_W-1:0] elem_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mme_pkg::POS_W-1:0]        out_row,
	output logic [mme_pkg::POS_W-1:0]        out_col,
	output logic signed [mme_pkg::ACC_W-1:0] product_value,
	output logic                             is_last,
	input  logic                             cfg_wr_en,
	input  logic [mme_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]        cfg_data
);
	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	// Dimension registers
	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(8);
			inner_dim_q <= DIM_W'(8);
			cols_b_q    <= DIM_W'(8);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped limits (count minus one)
	logic [DW-1:0] nr_lim, nk_lim, nc_lim;
	logic [AW-1:0] nk_step, nc_step;

	assign nr_lim  = DW'(clamp_m1(rows_a_q, DIM_W'(MAX_DIM)));
	assign nk_lim  = DW'(clamp_m1(inner_dim_q, DIM_W'(MAX_DIM)));
	assign nc_lim  = DW'(clamp_m1(cols_b_q, DIM_W'(MAX_DIM)));
	assign nk_step = AW'(nk_lim) + AW'(1);
	assign nc_step = AW'(nc_lim) + AW'(1);

	// Input acceptance
	logic busy_q;
	logic in_acc, do_wr_a, do_wr_b, do_start, idx_ok;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;
	assign idx_ok   = (IDX_W + 1)'(elem_index) < (IDX_W + 1)'(DEPTH);
	assign do_wr_a  = in_acc && (req_type == REQ_WRITE_A) && idx_ok;
	assign do_wr_b  = in_acc && (req_type == REQ_WRITE_B) && idx_ok;
	assign do_start = in_acc && (req_type == REQ_COMPUTE);

	// Sequencer state
	logic          run_q;
	logic [DW-1:0] r_q, c_q, k_q;
	logic [AW-1:0] a_base_q, a_addr_q, b_addr_q;
	logic          step;
	logic          end_k, end_c, end_r;
	mac_stat_t     stat;

	assign step  = run_q && stat.adv;
	assign end_k = (k_q == nk_lim);
	assign end_c = (c_q == nc_lim);
	assign end_r = (r_q == nr_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (do_start) begin
			busy_q <= 1'b1;
		end else if (stat.done) begin
			busy_q <= 1'b0;
		end
	end

	// Walk r, c, k with running store addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
		end else if (do_start) begin
			run_q    <= 1'b1;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
		end else if (step) begin
			if (!end_k) begin
				k_q      <= k_q + DW'(1);
				a_addr_q <= a_addr_q + AW'(1);
				b_addr_q <= b_addr_q + nc_step;
			end else begin
				k_q <= '0;
				if (!end_c) begin
					c_q      <= c_q + DW'(1);
					a_addr_q <= a_base_q;
					b_addr_q <= AW'(c_q) + AW'(1);
				end else begin
					c_q      <= '0;
					b_addr_q <= '0;
					if (end_r) begin
						run_q <= 1'b0;
					end else begin
						r_q      <= r_q + DW'(1);
						a_base_q <= a_base_q + nk_step;
						a_addr_q <= a_base_q + nk_step;
					end
				end
			end
		end
	end

	// Element stores: written by input words, read during the walk
	logic signed [VAL_W-1:0] mem_a [DEPTH];
	logic signed [VAL_W-1:0] mem_b [DEPTH];
	logic signed [VAL_W-1:0] a_s1, b_s1;
	logic [AW-1:0]           wr_addr;

	assign wr_addr = elem_index[AW-1:0];

	always_ff @(posedge clk) begin
		if (do_wr_a) begin
			mem_a[wr_addr] <= elem_value;
		end
		if (step) begin
			a_s1 <= mem_a[a_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr_b) begin
			mem_b[wr_addr] <= elem_value;
		end
		if (step) begin
			b_s1 <= mem_b[b_addr_q];
		end
	end

	// Read stage tag
	logic     v_s1;
	mac_tag_t tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stat.adv) begin
			v_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			tag_s1.first     <= (k_q == '0);
			tag_s1.last_term <= end_k;
			tag_s1.last_elem <= end_k && end_c && end_r;
			tag_s1.row       <= POS_W'(r_q);
			tag_s1.col       <= POS_W'(c_q);
		end
	end

	mme_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s1          (v_s1),
		.tag_s1        (tag_s1),
		.a_s1          (a_s1),
		.b_s1          (b_s1),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.is_last       (is_last)
	);

	// The walk only runs inside a busy compute
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q || v_s1) |-> busy_q)
		else $error("walk active outside a compute");

	// A stall freezes the walk position
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !stat.adv && !do_start) |=> $stable(k_q) && $stable(a_addr_q)
			&& $stable(b_addr_q))
		else $error("walk moved during stall");

	// Read addresses stay inside the stores
	a_addr_rng: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> ((32)'(a_addr_q) < DEPTH) && ((32)'(b_addr_q) < DEPTH))
		else $error("store read address out of range");

	// No store write while a compute reads the stores
	a_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !(do_wr_a || do_wr_b))
		else $error("store written during a compute");

endmodule
